// ----- sv/mdsl_pkg.sv -----
package mdsl_pkg;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned SPEED_W  = 12;
    localparam int unsigned DUTY_W   = 10;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    // Wide enough for speed differences and a four-fold step
    localparam int unsigned CALC_W = SPEED_W + 2;

    localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(1023);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SPEED = 2'd0,
        FUNC_STOP  = 2'd1,
        FUNC_BRAKE = 2'd2
    } func_t;

    typedef enum logic [MODE_W-1:0] {
        RAMP_DIRECT = 2'd0,
        RAMP_SLEW   = 2'd1,
        RAMP_KICK   = 2'd2
    } ramp_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAMP_MODE = 2'd0,
        REG_DUTY_STEP = 2'd1,
        REG_DEAD_ZONE = 2'd2
    } cfg_reg_t;

    localparam logic [MODE_W-1:0] RAMP_MODE_RESET = RAMP_KICK;
    localparam logic [DUTY_W-1:0] DUTY_STEP_RESET = DUTY_W'(8);
    localparam logic [DUTY_W-1:0] DEAD_ZONE_RESET = DUTY_W'(500);

    // Outcome of one command: duties plus the ramp state update
    typedef struct packed {
        logic                      state_we;
        logic signed [SPEED_W-1:0] last_speed;
        logic                      rotating;
        logic [DUTY_W-1:0]         forward_duty;
        logic [DUTY_W-1:0]         reverse_duty;
    } ramp_result_t;

endpackage

// ----- sv/mdsl_ramp.sv -----
module mdsl_ramp (
    input  logic [mdsl_pkg::FUNC_W-1:0]          func,
    input  logic signed [mdsl_pkg::SPEED_W-1:0]  speed,
    input  logic [mdsl_pkg::MODE_W-1:0]          ramp_mode,
    input  logic [mdsl_pkg::DUTY_W-1:0]          duty_step,
    input  logic [mdsl_pkg::DUTY_W-1:0]          dead_zone,
    input  logic signed [mdsl_pkg::SPEED_W-1:0]  last_speed,
    input  logic                                 rotating,
    output mdsl_pkg::ramp_result_t               result
);
    import mdsl_pkg::*;

    logic signed [CALC_W-1:0]  step_w;
    logic signed [CALC_W-1:0]  diff_w;
    logic signed [CALC_W-1:0]  prev_w;
    logic signed [CALC_W-1:0]  target_w;
    logic signed [CALC_W-1:0]  dz_w;
    logic signed [CALC_W-1:0]  limited_w;
    logic signed [SPEED_W-1:0] limited;
    logic signed [SPEED_W-1:0] shaped;
    logic signed [SPEED_W-1:0] clamped;
    logic                      fast_step;
    logic                      reach_dz;
    logic [SPEED_W-1:0]        mag;

    // Kick-off: four-fold step while stopped in the kick-off mode
    assign fast_step = (ramp_mode != RAMP_SLEW) && !rotating;
    assign step_w    = fast_step ? {2'b00, duty_step, 2'b00} : {4'b0000, duty_step};
    assign prev_w    = CALC_W'(last_speed);
    assign target_w  = CALC_W'(speed);
    assign diff_w    = target_w - prev_w;
    assign dz_w      = {4'b0000, dead_zone};

    always_comb begin
        if (diff_w > step_w) begin
            limited_w = prev_w + step_w;
        end else if (diff_w < -step_w) begin
            limited_w = prev_w - step_w;
        end else begin
            limited_w = target_w;
        end
    end

    // Always lies between last_speed and the command, so it fits
    assign limited  = limited_w[SPEED_W-1:0];
    assign reach_dz = (limited_w >= dz_w) || (limited_w <= -dz_w);

    always_comb begin
        result = '0;
        shaped = speed;
        case (ramp_mode)
            RAMP_DIRECT: begin
                shaped = speed;
            end
            RAMP_SLEW: begin
                shaped            = (speed == '0) ? speed : limited;
                result.state_we   = 1'b1;
                result.rotating   = rotating;
                result.last_speed = shaped;
            end
            default: begin
                // kick-off, also taken by the unused mode code
                result.state_we = 1'b1;
                if (speed == '0) begin
                    shaped          = speed;
                    result.rotating = 1'b0;
                end else begin
                    shaped          = limited;
                    result.rotating = rotating || reach_dz;
                end
                result.last_speed = shaped;
            end
        endcase

        if (shaped > SPEED_W'(1023)) begin
            clamped = SPEED_W'(1023);
        end else if (shaped < -SPEED_W'(1023)) begin
            clamped = -SPEED_W'(1023);
        end else begin
            clamped = shaped;
        end
        mag = clamped[SPEED_W-1] ? SPEED_W'(-clamped) : SPEED_W'(clamped);

        case (func)
            FUNC_SPEED: begin
                if (clamped[SPEED_W-1]) begin
                    result.reverse_duty = mag[DUTY_W-1:0];
                end else begin
                    result.forward_duty = mag[DUTY_W-1:0];
                end
            end
            FUNC_BRAKE: begin
                result.state_we     = 1'b0;
                result.forward_duty = DUTY_MAX;
                result.reverse_duty = DUTY_MAX;
            end
            default: begin
                // coast, also the unused func code
                result.state_we = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/motor_duty_slew_limiter_unit.sv -----
// Motor duty slew limiter: turns speed, coast and brake commands into the
// forward and reverse duty pair of an H-bridge.
//
// Input channel (s_valid/s_ready, s_func, s_speed): one command per beat.
// Result channel (m_valid/m_ready, m_forward_duty, m_reverse_duty): one
// duty pair per command, in command order. Config port (cfg_wr_en,
// cfg_index, cfg_wdata): ramp mode, duty step and dead zone. The user
// must write them only while no command is in flight; not enforced here.
//
// Path: an accepted beat enters the input register, then the ramp
// logic feeds the result register. Throughput: one beat per cycle while
// m_ready is high, set by the single register pair around the ramp logic,
// which also updates the ramp state in the same cycle.
// Reset (aresetn low, synchronous): both stages empty, ramp state back to
// stopped with last speed zero, registers back to kick-off mode, step 8,
// dead zone 500.
// Stall: while m_ready is low the result holds; one more beat is taken
// into the input register, after which s_ready drops.
module motor_duty_slew_limiter_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mdsl_pkg::FUNC_W-1:0]          s_func,
    input  logic signed [mdsl_pkg::SPEED_W-1:0]  s_speed,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mdsl_pkg::DUTY_W-1:0]          m_forward_duty,
    output logic [mdsl_pkg::DUTY_W-1:0]          m_reverse_duty,
    input  logic                                 cfg_wr_en,
    input  logic [mdsl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mdsl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import mdsl_pkg::*;

    // configuration
    logic [MODE_W-1:0] ramp_mode_reg;
    logic [DUTY_W-1:0] duty_step_reg;
    logic [DUTY_W-1:0] dead_zone_reg;

    // input stage
    logic                      in_valid_reg;
    logic [FUNC_W-1:0]         in_func_reg;
    logic signed [SPEED_W-1:0] in_speed_reg;

    // ramp state
    logic signed [SPEED_W-1:0] last_speed_reg;
    logic                      rotating_reg;

    // result stage
    logic                  out_valid_reg;
    logic [DUTY_W-1:0]     fwd_duty_reg;
    logic [DUTY_W-1:0]     rev_duty_reg;

    ramp_result_t ramp_res;
    logic         advance;
    logic         take_in;

    // the input stage moves on when the result register is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take_in = s_valid && s_ready;

    mdsl_ramp u_ramp (
        .func       (in_func_reg),
        .speed      (in_speed_reg),
        .ramp_mode  (ramp_mode_reg),
        .duty_step  (duty_step_reg),
        .dead_zone  (dead_zone_reg),
        .last_speed (last_speed_reg),
        .rotating   (rotating_reg),
        .result     (ramp_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_mode_reg <= RAMP_MODE_RESET;
            duty_step_reg <= DUTY_STEP_RESET;
            dead_zone_reg <= DEAD_ZONE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RAMP_MODE: ramp_mode_reg <= cfg_wdata[MODE_W-1:0];
                REG_DUTY_STEP: duty_step_reg <= cfg_wdata[DUTY_W-1:0];
                REG_DEAD_ZONE: dead_zone_reg <= cfg_wdata[DUTY_W-1:0];
                default: ;     // writes beyond the map are dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_func_reg  <= s_func;
            in_speed_reg <= s_speed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_speed_reg <= '0;
            rotating_reg   <= 1'b0;
        end else if (advance && ramp_res.state_we) begin
            last_speed_reg <= ramp_res.last_speed;
            rotating_reg   <= ramp_res.rotating;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fwd_duty_reg <= ramp_res.forward_duty;
            rev_duty_reg <= ramp_res.reverse_duty;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_forward_duty = fwd_duty_reg;
    assign m_reverse_duty = rev_duty_reg;

endmodule

// ----- sv/mdsl_checker.sv -----
module mdsl_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [mdsl_pkg::DUTY_W-1:0]        m_forward_duty,
    input logic [mdsl_pkg::DUTY_W-1:0]        m_reverse_duty
);
    import mdsl_pkg::*;

    // a stalled result keeps its duties
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_forward_duty)
                                && $stable(m_reverse_duty))
        else $error("stalled result changed");

    // only one bridge side driven, unless braking
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_forward_duty == '0) || (m_reverse_duty == '0)
                    || ((m_forward_duty == DUTY_MAX) && (m_reverse_duty == DUTY_MAX)))
        else $error("both bridge sides driven");

    // input back-pressure only from a stalled, full result stage
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

endmodule

bind motor_duty_slew_limiter_unit mdsl_checker u_mdsl_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_forward_duty (m_forward_duty),
    .m_reverse_duty (m_reverse_duty)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import mdsl_pkg::*;

    // Codes the package leaves unnamed; the block must still cope with them
    localparam logic [FUNC_W-1:0]    FUNC_SPARE = 2'd3;   // acts as coast
    localparam logic [MODE_W-1:0]    RAMP_SPARE = 2'd3;   // acts as kick-off
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;   // no register behind it

    localparam int KICK_FACTOR  = 4;
    localparam int DUTY_CEIL    = int'(DUTY_MAX);
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 8;     // slack after the last result
    localparam int SEGMENTS     = 6;     // register settings per idling phase
    localparam int SEG_COMMANDS = 30;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic [DUTY_W-1:0] forward;
        logic [DUTY_W-1:0] reverse;
    } duty_pair_t;

    typedef enum logic {ROW_CMD, ROW_REG} row_kind_t;

    // One directed step: a command beat, or a register write.
    // code is the func for a command and the register index for a write.
    typedef struct packed {
        row_kind_t                 kind;
        logic [1:0]                code;
        logic signed [SPEED_W-1:0] value;
        logic                      typed;
        logic [DUTY_W-1:0]         forward;
        logic [DUTY_W-1:0]         reverse;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 34;

    // Runs from the reset settings: kick-off mode, step 8, dead zone 500.
    // Duties are typed in where they are obvious; other rows use the predictor.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // coast, brake and the spare func code, then a first kick from rest
        '{ROW_CMD, FUNC_BRAKE, SPEED_W'(0),     1'b1, DUTY_W'(1023), DUTY_W'(1023)},
        '{ROW_CMD, FUNC_STOP,  SPEED_W'(0),     1'b1, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPARE, SPEED_W'(-1),    1'b1, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(2047),  1'b1, DUTY_W'(32),   DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(2047),  1'b0, DUTY_W'(0),    DUTY_W'(0)},
        // brake mid-ramp must leave the ramp where it was
        '{ROW_CMD, FUNC_BRAKE, SPEED_W'(-2048), 1'b1, DUTY_W'(1023), DUTY_W'(1023)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(-2048), 1'b0, DUTY_W'(0),    DUTY_W'(0)},
        // zero lands at once
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(0),     1'b1, DUTY_W'(0),    DUTY_W'(0)},
        // direct mode: clamp at both ends, smallest reverse duty
        '{ROW_REG, REG_RAMP_MODE, SPEED_W'(RAMP_DIRECT), 1'b0, DUTY_W'(0), DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(2047),  1'b1, DUTY_W'(1023), DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(-2048), 1'b1, DUTY_W'(0),    DUTY_W'(1023)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(-1),    1'b1, DUTY_W'(0),    DUTY_W'(1)},
        // slew mode with the widest step; stored speed runs past the clamp
        '{ROW_REG, REG_RAMP_MODE, SPEED_W'(RAMP_SLEW), 1'b0, DUTY_W'(0), DUTY_W'(0)},
        '{ROW_REG, REG_DUTY_STEP, SPEED_W'(1023),      1'b0, DUTY_W'(0), DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(2047),  1'b0, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(2047),  1'b0, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(-2048), 1'b0, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(-2048), 1'b0, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(-2048), 1'b0, DUTY_W'(0),    DUTY_W'(0)},
        // zero step holds a nonzero command, zero still lands
        '{ROW_REG, REG_DUTY_STEP, SPEED_W'(0),  1'b0, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(5),     1'b0, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(0),     1'b1, DUTY_W'(0),    DUTY_W'(0)},
        // spare mode behaves as kick-off; dead zone 0 trips rotation at once
        '{ROW_REG, REG_RAMP_MODE, SPEED_W'(RAMP_SPARE), 1'b0, DUTY_W'(0), DUTY_W'(0)},
        '{ROW_REG, REG_DUTY_STEP, SPEED_W'(1),  1'b0, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_REG, REG_DEAD_ZONE, SPEED_W'(0),  1'b0, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(100),   1'b0, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(100),   1'b0, DUTY_W'(0),    DUTY_W'(0)},
        // widest dead zone and step: full-scale kick, then a reversal
        '{ROW_REG, REG_DEAD_ZONE, SPEED_W'(1023), 1'b0, DUTY_W'(0),  DUTY_W'(0)},
        '{ROW_REG, REG_DUTY_STEP, SPEED_W'(1023), 1'b0, DUTY_W'(0),  DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(0),     1'b1, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(-2048), 1'b0, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_SPEED, SPEED_W'(2047),  1'b0, DUTY_W'(0),    DUTY_W'(0)},
        // write to the unused index must change nothing
        '{ROW_REG, REG_SPARE,  SPEED_W'(1023),  1'b0, DUTY_W'(0),    DUTY_W'(0)},
        '{ROW_CMD, FUNC_STOP,  SPEED_W'(2047),  1'b1, DUTY_W'(0),    DUTY_W'(0)}
    };

    // DUT connections; everything driven by the bench starts at a known value
    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [FUNC_W-1:0]         s_func         = '0;
    logic signed [SPEED_W-1:0] s_speed        = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic [DUTY_W-1:0]         m_forward_duty;
    logic [DUTY_W-1:0]         m_reverse_duty;
    logic                      cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [CFG_DATA_W-1:0]     cfg_wdata      = '0;

    // Predictor copy of the registers and ramp state
    logic [MODE_W-1:0]         cfg_mode     = RAMP_MODE_RESET;
    logic [DUTY_W-1:0]         cfg_step     = DUTY_STEP_RESET;
    logic [DUTY_W-1:0]         cfg_dz       = DEAD_ZONE_RESET;
    logic signed [SPEED_W-1:0] ramp_speed   = '0;
    logic                      ramp_running = 1'b0;

    duty_pair_t duty_pending_q [$];
    int         error_count       = 0;
    int         sender_idle_pct   = 22;
    int         receiver_idle_pct = 57;

    motor_duty_slew_limiter_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_speed        (s_speed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_forward_duty (m_forward_duty),
        .m_reverse_duty (m_reverse_duty),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Move from 'from' towards 'target' by no more than 'limit'
    function automatic int slew_toward(int target, int from, int limit);
        if (target - from > limit)
            return from + limit;
        if (target - from < -limit)
            return from - limit;
        return target;
    endfunction

    // Duty pair for one command; updates the ramp state as the block would.
    // Coast and brake (and the spare func) leave the ramp alone.
    function automatic duty_pair_t duty_for_command(input logic [FUNC_W-1:0] func,
                                                    input logic signed [SPEED_W-1:0] speed);
        int         cmd;
        int         step;
        int         dz;
        duty_pair_t duty;
        cmd  = speed;
        step = cfg_step;
        dz   = cfg_dz;
        duty = '0;
        if (func == FUNC_BRAKE) begin
            duty.forward = DUTY_MAX;
            duty.reverse = DUTY_MAX;
            return duty;
        end
        if (func != FUNC_SPEED)
            return duty;

        if (cfg_mode == RAMP_SLEW) begin
            if (cmd != 0)
                cmd = slew_toward(cmd, ramp_speed, step);
            ramp_speed = cmd[SPEED_W-1:0];
        end else if (cfg_mode != RAMP_DIRECT) begin
            // kick-off (and the spare mode code)
            if (cmd == 0) begin
                ramp_running = 1'b0;
            end else if (!ramp_running) begin
                cmd = slew_toward(cmd, ramp_speed, KICK_FACTOR * step);
                if (cmd >= dz || cmd <= -dz)
                    ramp_running = 1'b1;
            end else begin
                cmd = slew_toward(cmd, ramp_speed, step);
            end
            ramp_speed = cmd[SPEED_W-1:0];
        end

        // stored speed is pre-clamp; only the output is limited
        if (cmd > DUTY_CEIL)
            cmd = DUTY_CEIL;
        if (cmd < -DUTY_CEIL)
            cmd = -DUTY_CEIL;
        if (cmd >= 0)
            duty.forward = DUTY_W'(cmd);
        else
            duty.reverse = DUTY_W'(-cmd);
        return duty;
    endfunction

    // Called at a clock edge. Leaves s_valid high after the beat is taken so a
    // following beat can go out back-to-back; the next caller lowers it if not.
    task automatic send_command(input logic [FUNC_W-1:0] func,
                                input logic signed [SPEED_W-1:0] speed,
                                input logic typed, input duty_pair_t typed_duty);
        duty_pair_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= func;
        s_speed <= speed;
        do @(posedge aclk); while (!s_ready);
        predicted = duty_for_command(func, speed);
        duty_pending_q.push_back(typed ? typed_duty : predicted);
    endtask

    // Register writes only go in once every outstanding beat has come back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        do @(posedge aclk); while (duty_pending_q.size() != 0);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_RAMP_MODE: cfg_mode = data[MODE_W-1:0];
            REG_DUTY_STEP: cfg_step = data;
            REG_DEAD_ZONE: cfg_dz   = data;
            default: ;
        endcase
    endtask

    // Result beats against the oldest pending duty pair
    always @(posedge aclk) begin : result_check
        duty_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (duty_pending_q.size() == 0) begin
                report_mismatch("unexpected result beat, forward", m_forward_duty, -1);
            end else begin
                want = duty_pending_q.pop_front();
                if (m_forward_duty !== want.forward)
                    report_mismatch("forward_duty", m_forward_duty, want.forward);
                if (m_reverse_duty !== want.reverse)
                    report_mismatch("reverse_duty", m_reverse_duty, want.reverse);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        directed_row_t             row;
        logic [FUNC_W-1:0]         func;
        logic signed [SPEED_W-1:0] speed;
        logic signed [SPEED_W-1:0] target_speed;
        logic [MODE_W-1:0]         mode;
        logic [CFG_DATA_W-1:0]     step;
        logic [CFG_DATA_W-1:0]     dz;
        int                        run_left;
        int                        pick;

        target_speed = '0;
        run_left     = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_REG)
                write_reg(row.code, row.value[CFG_DATA_W-1:0]);
            else
                send_command(row.code, row.value, row.typed, {row.forward, row.reverse});
        end

        // Random part: sender-light/receiver-heavy idling, then swapped, then none
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 22; receiver_idle_pct = 57; end
                1: begin sender_idle_pct = 57; receiver_idle_pct = 22; end
                default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
            endcase

            for (int seg = 0; seg < SEGMENTS; seg++) begin
                // extremes first, then a couple of random settings with small
                // steps and dead zones favoured so kick-off actually completes
                case (seg)
                    0: begin mode = RAMP_DIRECT; step = 10'd1023; dz = 10'd0;    end
                    1: begin mode = RAMP_SLEW;   step = 10'd1;    dz = 10'd1023; end
                    2: begin mode = RAMP_KICK;   step = 10'd1023; dz = 10'd1023; end
                    3: begin mode = RAMP_SPARE;  step = 10'd0;    dz = 10'd0;    end
                    default: begin
                        mode = MODE_W'($urandom_range(0, 3));
                        step = $urandom_range(1) ? CFG_DATA_W'($urandom_range(1, 64))
                                                 : CFG_DATA_W'($urandom_range(0, 1023));
                        dz   = $urandom_range(1) ? CFG_DATA_W'($urandom_range(0, 300))
                                                 : CFG_DATA_W'($urandom_range(0, 1023));
                    end
                endcase
                write_reg(REG_RAMP_MODE, CFG_DATA_W'(mode));
                write_reg(REG_DUTY_STEP, step);
                write_reg(REG_DEAD_ZONE, dz);

                for (int n = 0; n < SEG_COMMANDS; n++) begin
                    // sender holds off until the pipe has fully drained
                    if (seg == 1 && n == SEG_COMMANDS / 2) begin
                        s_valid <= 1'b0;
                        do @(posedge aclk); while (duty_pending_q.size() != 0);
                    end

                    // mostly runs of one target so the ramps get somewhere
                    if (run_left == 0) begin
                        case ($urandom_range(7))
                            0: target_speed = '0;
                            1: begin
                                case ($urandom_range(3))
                                    0: target_speed = SPEED_W'(2047);
                                    1: target_speed = SPEED_W'(-2048);
                                    2: target_speed = SPEED_W'(1023);
                                    default: target_speed = SPEED_W'(-1023);
                                endcase
                            end
                            default: target_speed = SPEED_W'($urandom);
                        endcase
                        run_left = $urandom_range(1, 24);
                    end

                    pick = $urandom_range(99);
                    if (pick < 6) begin
                        func  = FUNC_W'($urandom_range(1, 3));   // coast, brake, spare
                        speed = SPEED_W'($urandom);
                    end else if (pick < 10) begin
                        func  = FUNC_SPEED;
                        speed = SPEED_W'($urandom);
                    end else begin
                        func  = FUNC_SPEED;
                        speed = target_speed;
                        run_left--;
                    end
                    send_command(func, speed, 1'b0, '0);
                end
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (duty_pending_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
